### hdl/lltp_pkg.sv
package lltp_pkg;
    localparam int ADDR_BITS  = 16;
    localparam int VALUE_BITS = 18;
    localparam int CNT_BITS   = ADDR_BITS + 1;
    localparam int LINK_BITS  = ADDR_BITS + 1;
    localparam int THR_BITS   = VALUE_BITS - 1;
    localparam int PADDR_BITS = 4;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_FETCH = 2'd2;

    localparam logic [PADDR_BITS-1:0] REG_HEAD_ADDR = 4'h0;
    localparam logic [PADDR_BITS-1:0] REG_HEAD_NULL = 4'h4;
    localparam logic [PADDR_BITS-1:0] REG_THRESHOLD = 4'h8;

    localparam int IN_BYTES  = (ADDR_BITS + VALUE_BITS + ADDR_BITS + 1 + 7) / 8;
    localparam int OUT_BYTES = (ADDR_BITS + VALUE_BITS + ADDR_BITS + 7) / 8;
endpackage

### hdl/linked_list_three_way_partition_top.sv
// channel | dir | width              | contents
// s_axis  | in  | tdata 56, tuser 2  | node load, start, fetch requests
// m_axis  | out | tdata 56, tlast 1  | reordered node per fetch
// apb     | in  | 32                 | head_address, head_is_null, threshold
// load: written as it is taken. fetch: order read, then value read, then next order held.
// start: each node is read, then evaluated, one at a time through the single read port of
// the value and link memories; the walk is three passes over the list.
// reset clears the control state only; the memories hold nothing until loaded.
// a result waits in the output register; the next request is taken meanwhile
// unless it is a fetch, which waits until the register is free.
module linked_list_three_way_partition_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // node_address, node_value, next_address, next_is_null (low bit up)
    input  logic [lltp_pkg::IN_BYTES*8-1:0] s_axis_tdata,
    // mode
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_address, out_value, out_next_address (low bit up)
    output logic [lltp_pkg::OUT_BYTES*8-1:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [lltp_pkg::PADDR_BITS-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int AB = lltp_pkg::ADDR_BITS;
    localparam int VB = lltp_pkg::VALUE_BITS;
    localparam int CB = lltp_pkg::CNT_BITS;
    localparam int LB = lltp_pkg::LINK_BITS;
    localparam int DEPTH = 1 << AB;

    typedef enum logic [3:0] {
        ST_IDLE, ST_WALK_RD, ST_WALK_EV, ST_F_RD, ST_F_WAIT, ST_F_OUT
    } state_t;

    state_t state_reg;
    logic [AB-1:0] head_reg;
    logic head_null_reg;
    logic [lltp_pkg::THR_BITS-1:0] thr_reg;
    logic [CB-1:0] count_reg, fpos_reg, steps_reg;
    logic [1:0] cls_reg;
    logic [AB-1:0] addr_reg, fa_reg;
    logic fl_reg;

    // memory ports
    logic v_we, l_we, o_we;
    logic [AB-1:0] v_waddr, v_raddr, o_waddr, o_raddr;
    logic [VB-1:0] v_wdata, v_rdata;
    logic [LB-1:0] l_wdata, l_rdata;
    logic [AB-1:0] o_rdata;

    logic [AB-1:0] in_node, in_next;
    logic [VB-1:0] in_val;
    logic in_nnull;
    logic req;

    assign in_node  = s_axis_tdata[AB-1:0];
    assign in_val   = s_axis_tdata[AB+VB-1:AB];
    assign in_next  = s_axis_tdata[2*AB+VB-1:AB+VB];
    assign in_nnull = s_axis_tdata[2*AB+VB];

    assign s_axis_tready = (state_reg == ST_IDLE) &&
                           (!m_axis_tvalid || s_axis_tuser != lltp_pkg::MODE_FETCH);
    assign req = s_axis_tvalid && s_axis_tready;

    lltp_ram #(.WIDTH(VB), .DEPTH(DEPTH)) u_value (
        .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
        .raddr(v_raddr), .rdata(v_rdata));
    lltp_ram #(.WIDTH(LB), .DEPTH(DEPTH)) u_link (
        .clk(clk), .we(l_we), .waddr(v_waddr), .wdata(l_wdata),
        .raddr(v_raddr), .rdata(l_rdata));
    lltp_ram #(.WIDTH(AB), .DEPTH(DEPTH)) u_order (
        .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(addr_reg),
        .raddr(o_raddr), .rdata(o_rdata));

    // class of the node just read
    logic [1:0] node_cls;
    logic signed [VB-1:0] sval;
    assign sval = v_rdata;
    always_comb
    begin
        if (sval < 0)
            node_cls = 2'd0;
        else if ({1'b0, v_rdata[VB-2:0]} <= {1'b0, thr_reg})
            node_cls = 2'd1;
        else
            node_cls = 2'd2;
    end

    always_comb
    begin
        v_we    = req && s_axis_tuser == lltp_pkg::MODE_LOAD;
        l_we    = v_we;
        v_waddr = in_node;
        v_wdata = in_val;
        l_wdata = {in_nnull, in_next};
        // fetch: value read from the order entry, then held on the captured address
        if (state_reg == ST_F_RD)
            v_raddr = o_rdata;
        else if (state_reg == ST_F_WAIT)
            v_raddr = fa_reg;
        else
            v_raddr = addr_reg;
        o_we    = (state_reg == ST_WALK_EV) && node_cls == cls_reg &&
                  count_reg < CB'(DEPTH);
        o_waddr = count_reg[AB-1:0];
        o_raddr = (state_reg == ST_IDLE) ? fpos_reg[AB-1:0] : AB'(fpos_reg + 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            head_null_reg <= 1'b0;
            thr_reg       <= '0;
            count_reg     <= '0;
            fpos_reg      <= '0;
            steps_reg     <= '0;
            cls_reg       <= '0;
            addr_reg      <= '0;
            fa_reg        <= '0;
            fl_reg        <= 1'b0;
            m_axis_tdata  <= '0;
            m_axis_tlast  <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                m_axis_tvalid <= 1'b0;
            if (psel && penable && pwrite)
            begin
                case (paddr)
                    lltp_pkg::REG_HEAD_ADDR: head_reg <= pwdata[AB-1:0];
                    lltp_pkg::REG_HEAD_NULL: head_null_reg <= pwdata[0];
                    lltp_pkg::REG_THRESHOLD: thr_reg <= pwdata[lltp_pkg::THR_BITS-1:0];
                    default: ;
                endcase
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (req && s_axis_tuser == lltp_pkg::MODE_START)
                    begin
                        count_reg <= '0;
                        fpos_reg  <= '0;
                        cls_reg   <= 2'd0;
                        steps_reg <= '0;
                        addr_reg  <= head_reg;
                        if (!head_null_reg)
                            state_reg <= ST_WALK_RD;
                    end
                    else if (req && s_axis_tuser == lltp_pkg::MODE_FETCH)
                    begin
                        if (fpos_reg < count_reg)
                            state_reg <= ST_F_RD;
                    end
                end
                ST_WALK_RD: state_reg <= ST_WALK_EV;
                ST_WALK_EV:
                begin
                    if (o_we)
                        count_reg <= count_reg + 1'b1;
                    if (l_rdata[AB] || steps_reg == CB'(DEPTH - 1))
                    begin
                        addr_reg  <= head_reg;
                        steps_reg <= '0;
                        if (cls_reg == 2'd2)
                            state_reg <= ST_IDLE;
                        else
                        begin
                            cls_reg   <= cls_reg + 1'b1;
                            state_reg <= ST_WALK_RD;
                        end
                    end
                    else
                    begin
                        addr_reg  <= l_rdata[AB-1:0];
                        steps_reg <= steps_reg + 1'b1;
                        state_reg <= ST_WALK_RD;
                    end
                end
                ST_F_RD:
                begin
                    // order entry of this position is on the read port now
                    fa_reg    <= o_rdata;
                    state_reg <= ST_F_WAIT;
                end
                ST_F_WAIT:
                begin
                    fl_reg    <= (fpos_reg + 1'b1) >= count_reg;
                    state_reg <= ST_F_OUT;
                end
                ST_F_OUT:
                begin
                    m_axis_tdata  <= {{(lltp_pkg::OUT_BYTES*8-2*AB-VB){1'b0}},
                                      fl_reg ? AB'(0) : o_rdata, v_rdata, fa_reg};
                    m_axis_tlast  <= fl_reg;
                    m_axis_tvalid <= 1'b1;
                    fpos_reg      <= fpos_reg + 1'b1;
                    state_reg     <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign pready = 1'b1;
    always_comb
    begin
        case (paddr)
            lltp_pkg::REG_HEAD_ADDR: prdata = 32'(head_reg);
            lltp_pkg::REG_HEAD_NULL: prdata = 32'(head_null_reg);
            lltp_pkg::REG_THRESHOLD: prdata = 32'(thr_reg);
            default: prdata = '0;
        endcase
    end

    // ordering never runs past its fill count
    a_fpos: assert property (@(posedge clk) disable iff (!rst_n)
        fpos_reg <= count_reg) else $error("fetch position beyond count");
    // a result is produced only after a fetch read sequence
    a_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg) == ST_F_OUT)
        else $error("result without fetch");
    // no request taken during a walk
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK_RD || state_reg == ST_WALK_EV) |-> !s_axis_tready)
        else $error("request taken while walking");
endmodule

### hdl/lltp_ram.sv
module lltp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
